// ----- hdl/assert_macros.svh -----
// Assertion macros used by the RTL of the freshness gate.
// Each macro expects clk_i and rst_ni to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/gffg_pkg.sv -----
// Types and constants of the GNSS fix freshness gate.
// No dependencies; gffg_regs and the gate import this package.
`timescale 1ns / 1ps

package gffg_pkg;

  // Configuration port geometry
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_MAX_HORIZONTAL_ACC = 3'd0;
  localparam logic [2:0] REG_MAX_VERTICAL_ACC   = 3'd1;
  localparam logic [2:0] REG_MAX_SPEED_ACC      = 3'd2;
  localparam logic [2:0] REG_STABLE_NEEDED      = 3'd3;
  localparam logic [2:0] REG_RECENT_WINDOW      = 3'd4;
  localparam logic [2:0] REG_FIX_TYPE_MASK      = 3'd5;

  // Register reset values
  localparam logic [31:0] RST_MAX_HORIZONTAL_ACC = 32'd5000;
  localparam logic [31:0] RST_MAX_VERTICAL_ACC   = 32'd10000;
  localparam logic [31:0] RST_MAX_SPEED_ACC      = 32'd1000;
  localparam logic [7:0]  RST_STABLE_NEEDED      = 8'd5;
  localparam logic [31:0] RST_RECENT_WINDOW      = 32'd1000;
  localparam logic [7:0]  RST_FIX_TYPE_MASK      = 8'd0;

  // Coordinate plausibility limits
  localparam logic signed [31:0] LAT_MIN = -32'sd900000000;
  localparam logic signed [31:0] LAT_MAX = 32'sd900000000;
  localparam logic signed [31:0] LON_MIN = -32'sd1800000000;
  localparam logic signed [31:0] LON_MAX = 32'sd1800000000;
  localparam logic signed [31:0] ALT_MIN = -32'sd1000000;
  localparam logic signed [31:0] ALT_MAX = 32'sd20000000;

  // Fetch status codes; any other nonzero code is a size mismatch
  localparam logic [1:0] FETCH_OK        = 2'd0;
  localparam logic [1:0] FETCH_COPY_FAIL = 2'd1;

  typedef enum logic [2:0] {
    EV_NO_SAMPLE     = 3'd0,
    EV_STALE         = 3'd1,
    EV_COPY_FAIL     = 3'd2,
    EV_SIZE_MISMATCH = 3'd3,
    EV_PUBLISHED     = 3'd4,
    EV_PUB_FAIL      = 3'd5
  } event_e;

  typedef struct packed {
    logic [31:0] max_horizontal_acc;
    logic [31:0] max_vertical_acc;
    logic [31:0] max_speed_acc;
    logic [7:0]  stable_needed;
    logic [31:0] recent_window;
    logic [7:0]  fix_type_mask;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        generation;
    logic [1:0]         fetch_status;
    logic               publish_ok;
    logic [63:0]        fix_stamp_ns;
    logic [2:0]         fix_kind;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic signed [31:0] altitude;
    logic [31:0]        horiz_acc;
    logic [31:0]        vert_acc;
    logic [31:0]        speed_acc;
    logic [47:0]        now_ms;
  } poll_t;

  typedef struct packed {
    event_e     event_res;
    logic       restart_seen;
    logic       sample_usable;
    logic [7:0] stable_count;
    logic       ready_res;
  } res_t;

endpackage

// ----- hdl/gffg_if.sv -----
// Stream channels of the freshness gate: poll beats in, result beats out.
// Standalone; widths follow the field list of the block.
`timescale 1ns / 1ps

interface gffg_poll_if;
  logic               valid;
  logic               ready;
  logic [31:0]        generation;
  logic [1:0]         fetch_status;
  logic               publish_ok;
  logic [63:0]        fix_stamp_ns;
  logic [2:0]         fix_kind;
  logic signed [31:0] latitude;
  logic signed [31:0] longitude;
  logic signed [31:0] altitude;
  logic [31:0]        horiz_acc;
  logic [31:0]        vert_acc;
  logic [31:0]        speed_acc;
  logic [47:0]        now_ms;

  modport source (
    output valid, generation, fetch_status, publish_ok, fix_stamp_ns, fix_kind,
           latitude, longitude, altitude, horiz_acc, vert_acc, speed_acc, now_ms,
    input  ready
  );
  modport sink (
    input  valid, generation, fetch_status, publish_ok, fix_stamp_ns, fix_kind,
           latitude, longitude, altitude, horiz_acc, vert_acc, speed_acc, now_ms,
    output ready
  );
endinterface

interface gffg_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic       restart_seen;
  logic       sample_usable;
  logic [7:0] stable_count;
  logic       ready_res;

  modport source (
    output valid, event_res, restart_seen, sample_usable, stable_count, ready_res,
    input  ready
  );
  modport sink (
    input  valid, event_res, restart_seen, sample_usable, stable_count, ready_res,
    output ready
  );
endinterface

// ----- hdl/gffg_regs.sv -----
// APB configuration registers of the freshness gate.
// Depends on gffg_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module gffg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gffg_pkg::ADDR_W-1:0]   paddr,
  input  logic [gffg_pkg::DATA_W-1:0]   pwdata,
  output logic [gffg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output gffg_pkg::cfg_t                cfg_o
);
  import gffg_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_o   = cfg_q;

  // Write the addressed register in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_horizontal_acc <= RST_MAX_HORIZONTAL_ACC;
      cfg_q.max_vertical_acc   <= RST_MAX_VERTICAL_ACC;
      cfg_q.max_speed_acc      <= RST_MAX_SPEED_ACC;
      cfg_q.stable_needed      <= RST_STABLE_NEEDED;
      cfg_q.recent_window      <= RST_RECENT_WINDOW;
      cfg_q.fix_type_mask      <= RST_FIX_TYPE_MASK;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MAX_HORIZONTAL_ACC: cfg_q.max_horizontal_acc <= pwdata;
        REG_MAX_VERTICAL_ACC:   cfg_q.max_vertical_acc   <= pwdata;
        REG_MAX_SPEED_ACC:      cfg_q.max_speed_acc      <= pwdata;
        REG_STABLE_NEEDED:      cfg_q.stable_needed      <= pwdata[7:0];
        REG_RECENT_WINDOW:      cfg_q.recent_window      <= pwdata;
        REG_FIX_TYPE_MASK:      cfg_q.fix_type_mask      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back; unmapped addresses return zero
  always_comb begin
    unique case (reg_idx)
      REG_MAX_HORIZONTAL_ACC: prdata = cfg_q.max_horizontal_acc;
      REG_MAX_VERTICAL_ACC:   prdata = cfg_q.max_vertical_acc;
      REG_MAX_SPEED_ACC:      prdata = cfg_q.max_speed_acc;
      REG_STABLE_NEEDED:      prdata = {24'd0, cfg_q.stable_needed};
      REG_RECENT_WINDOW:      prdata = cfg_q.recent_window;
      REG_FIX_TYPE_MASK:      prdata = {24'd0, cfg_q.fix_type_mask};
      default:                prdata = '0;
    endcase
  end

endmodule

// ----- hdl/gnss_fix_freshness_gate.sv -----
// GNSS fix freshness gate: classifies each poll beat, tracks the stable count
// and reports readiness. Depends on gffg_pkg, gffg_if, gffg_regs and assert_macros.svh.
`timescale 1ns / 1ps

// One poll beat is taken per clock cycle as long as the result side does not
// stall. The poll sits in the input register while it is evaluated, and the
// result register then loads its result beat, which is presented from there.
// Both registers advance whenever the result register is empty or its beat is
// taken, so a stalled result still leaves room for one more poll. The gate
// state (last generation, stable count, last sample time) is updated in the
// evaluation cycle, so polls are judged strictly in arrival order.
// Configuration is written over the APB port at byte address 4 * index and
// must only change while no beat is in flight.
module gnss_fix_freshness_gate (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gffg_pkg::ADDR_W-1:0]   paddr,
  input  logic [gffg_pkg::DATA_W-1:0]   pwdata,
  output logic [gffg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  gffg_poll_if.sink                     poll_i,
  gffg_res_if.source                    res_o
);
  import gffg_pkg::*;

  `include "assert_macros.svh"

  cfg_t cfg;

  gffg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pipeline control
  logic  in_valid_q;
  poll_t in_q;
  logic  res_valid_q;
  res_t  res_q;
  logic  advance;
  logic  eval_fire;

  assign advance      = !res_valid_q || res_o.ready;
  assign eval_fire    = in_valid_q && advance;
  assign poll_i.ready = !in_valid_q || advance;

  // Gate state
  logic        seen_q;
  logic [31:0] last_gen_q;
  logic [7:0]  cnt_q;
  logic        usable_q;
  logic        have_q;
  logic [47:0] last_time_q;

  // Capture the poll beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (poll_i.ready) begin
      in_valid_q <= poll_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poll_i.ready && poll_i.valid) begin
      in_q.generation   <= poll_i.generation;
      in_q.fetch_status <= poll_i.fetch_status;
      in_q.publish_ok   <= poll_i.publish_ok;
      in_q.fix_stamp_ns <= poll_i.fix_stamp_ns;
      in_q.fix_kind     <= poll_i.fix_kind;
      in_q.latitude     <= poll_i.latitude;
      in_q.longitude    <= poll_i.longitude;
      in_q.altitude     <= poll_i.altitude;
      in_q.horiz_acc    <= poll_i.horiz_acc;
      in_q.vert_acc     <= poll_i.vert_acc;
      in_q.speed_acc    <= poll_i.speed_acc;
      in_q.now_ms       <= poll_i.now_ms;
    end
  end

  // Classify the poll
  logic   gen_zero;
  logic   stale;
  logic   accept;
  logic   restart;
  logic   fix_ok;
  logic   use_fix;
  event_e event_d;

  assign gen_zero = (in_q.generation == '0);
  assign stale    = seen_q && (in_q.generation == last_gen_q);
  assign accept   = !gen_zero && !stale && (in_q.fetch_status == FETCH_OK);
  assign restart  = accept && seen_q && (in_q.generation < last_gen_q);

  always_comb begin
    priority if (gen_zero) begin
      event_d = EV_NO_SAMPLE;
    end else if (stale) begin
      event_d = EV_STALE;
    end else if (in_q.fetch_status == FETCH_COPY_FAIL) begin
      event_d = EV_COPY_FAIL;
    end else if (in_q.fetch_status != FETCH_OK) begin
      event_d = EV_SIZE_MISMATCH;
    end else if (in_q.publish_ok) begin
      event_d = EV_PUBLISHED;
    end else begin
      event_d = EV_PUB_FAIL;
    end
  end

  // Check the fix against a nonzero stamp, ranges, accuracy limits and the fix type mask
  assign fix_ok = (in_q.fix_stamp_ns != '0) &&
                  cfg.fix_type_mask[in_q.fix_kind] &&
                  (in_q.latitude  >= LAT_MIN) && (in_q.latitude  <= LAT_MAX) &&
                  (in_q.longitude >= LON_MIN) && (in_q.longitude <= LON_MAX) &&
                  (in_q.altitude  >= ALT_MIN) && (in_q.altitude  <= ALT_MAX) &&
                  (in_q.horiz_acc <= cfg.max_horizontal_acc) &&
                  (in_q.vert_acc  <= cfg.max_vertical_acc) &&
                  (in_q.speed_acc <= cfg.max_speed_acc);
  assign use_fix = fix_ok && in_q.publish_ok;

  // Advance the stable count: clear on an unusable fix, count from zero on restart, saturate at the limit
  logic [7:0] cnt_base;
  logic [7:0] cnt_new;

  assign cnt_base = restart ? 8'd0 : cnt_q;
  always_comb begin
    if (!use_fix) begin
      cnt_new = 8'd0;
    end else if (cnt_base < cfg.stable_needed) begin
      cnt_new = cnt_base + 8'd1;
    end else begin
      cnt_new = cnt_base;
    end
  end

  // Readiness at this poll's time; a fresh sample has age zero
  logic [47:0] age;
  logic        ready_hold;
  logic        ready_d;

  assign age        = in_q.now_ms - last_time_q;
  assign ready_hold = usable_q && (cnt_q >= cfg.stable_needed) && have_q &&
                      (in_q.now_ms >= last_time_q) &&
                      (age <= {16'd0, cfg.recent_window});
  assign ready_d    = accept ? (use_fix && (cnt_new >= cfg.stable_needed)) : ready_hold;

  // Update the gate state on an accepted sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      last_gen_q  <= '0;
      cnt_q       <= '0;
      usable_q    <= 1'b0;
      have_q      <= 1'b0;
      last_time_q <= '0;
    end else if (eval_fire && accept) begin
      seen_q      <= 1'b1;
      last_gen_q  <= in_q.generation;
      cnt_q       <= cnt_new;
      usable_q    <= use_fix;
      have_q      <= 1'b1;
      last_time_q <= in_q.now_ms;
    end
  end

  // Hold the result beat until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_fire) begin
      res_q.event_res     <= event_d;
      res_q.restart_seen  <= restart;
      res_q.sample_usable <= accept ? use_fix : usable_q;
      res_q.stable_count  <= accept ? cnt_new : cnt_q;
      res_q.ready_res     <= ready_d;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.event_res     = res_q.event_res;
  assign res_o.restart_seen  = res_q.restart_seen;
  assign res_o.sample_usable = res_q.sample_usable;
  assign res_o.stable_count  = res_q.stable_count;
  assign res_o.ready_res     = res_q.ready_res;

  // A captured poll is never dropped while the result side stalls
  `ASSERT_NEXT(a_in_hold, in_valid_q && !advance, in_valid_q)
  // An evaluated accepted sample always leaves a sample time behind
  `ASSERT_NEXT(a_have_after_accept, eval_fire && accept, have_q && seen_q)
  // A restart is only reported on an accepted sample
  `ASSERT_IMPL(a_restart_event, res_o.valid && res_o.restart_seen,
               res_q.event_res == EV_PUBLISHED || res_q.event_res == EV_PUB_FAIL)
  // A failed publish never leaves a usable sample
  `ASSERT_IMPL(a_pub_fail_unusable, res_o.valid && res_q.event_res == EV_PUB_FAIL,
               !res_o.sample_usable && !res_o.ready_res)

endmodule
